@@ rtl/core/c2p_pkg.sv @@
// ----------------------------------------------------------------------------
// c2p_pkg
// Shared constants, types and helper functions of the dithered
// chunky-to-planar converter.
// ----------------------------------------------------------------------------
`default_nettype none

package c2p_pkg;

  localparam int unsigned SRC_WIDTH  = 160;
  localparam int unsigned SRC_HEIGHT = 100;

  localparam int unsigned COL_W   = $clog2(SRC_WIDTH);
  localparam int unsigned ROW_W   = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;
  localparam int unsigned CHAN_W  = 4;
  localparam int unsigned KEY_W   = 3 * CHAN_W;
  localparam int unsigned COLOR_W = 4;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned DROW_W  = 8;
  localparam int unsigned GRP_W   = 5;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 4'd15;

  typedef struct packed {
    logic               we;
    logic [KEY_W-1:0]   addr;
    logic [COLOR_W-1:0] data;
  } c2p_wr_t;

  // travels alongside the table read data
  typedef struct packed {
    logic              valid;
    logic              phase;
    logic [2:0]        pos_hi;
    logic              clear;
    logic              emit;
    logic [DROW_W-1:0] dest_row;
    logic [GRP_W-1:0]  grp;
    logic              frame_end;
  } c2p_tag_t;

  function automatic logic [3:0] bayer(input logic [1:0] y, input logic [1:0] x);
    logic [3:0] d;
    case ({y, x})
      4'h0: d = 4'd0;
      4'h1: d = 4'd8;
      4'h2: d = 4'd2;
      4'h3: d = 4'd10;
      4'h4: d = 4'd12;
      4'h5: d = 4'd4;
      4'h6: d = 4'd14;
      4'h7: d = 4'd6;
      4'h8: d = 4'd3;
      4'h9: d = 4'd11;
      4'hA: d = 4'd1;
      4'hB: d = 4'd9;
      4'hC: d = 4'd15;
      4'hD: d = 4'd7;
      4'hE: d = 4'd13;
      default: d = 4'd5;
    endcase
    return d;
  endfunction

  // c + floor((d-8)/4), clamped to 0..15
  function automatic logic [CHAN_W-1:0] clamp_chan(input logic [CHAN_W-1:0] c,
                                                   input logic [3:0] d);
    logic [CHAN_W:0] v;
    logic [CHAN_W:0] w;
    v = {1'b0, c} + {3'b000, d[3:2]};
    w = v - 5'd2;
    if (v < 5'd2) begin
      return '0;
    end else if (w > {1'b0, CHAN_MAX}) begin
      return CHAN_MAX;
    end else begin
      return w[CHAN_W-1:0];
    end
  endfunction

  function automatic logic [KEY_W-1:0] dither_key(input logic [15:0] rgb,
                                                  input logic [3:0] d);
    return {clamp_chan(rgb[15:12], d), clamp_chan(rgb[11:8], d),
            clamp_chan(rgb[3:0], d)};
  endfunction

  // bit plane*16 + (15-pos) gets color bit plane
  function automatic logic [WORD_W-1:0] plane_mask(input logic [COLOR_W-1:0] color,
                                                   input logic [3:0] pos);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int p = 0; p < COLOR_W; p++) begin
      m[{2'(p), ~pos}] = color[p];
    end
    return m;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/c2p_lut_ram.sv @@
// ----------------------------------------------------------------------------
// c2p_lut_ram
// Palette table: 4096 x 4, one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module c2p_lut_ram (
  input  wire logic                          clk_i,
  input  wire c2p_pkg::c2p_wr_t              wr_i,
  input  wire logic [c2p_pkg::KEY_W-1:0]     rd_addr_a_i,
  input  wire logic [c2p_pkg::KEY_W-1:0]     rd_addr_b_i,
  output logic      [c2p_pkg::COLOR_W-1:0]   rd_data_a_o,
  output logic      [c2p_pkg::COLOR_W-1:0]   rd_data_b_o
);
  import c2p_pkg::*;

  logic [COLOR_W-1:0] mem [2**KEY_W];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_a_o <= mem[rd_addr_a_i];
    rd_data_b_o <= mem[rd_addr_b_i];
  end

endmodule

`default_nettype wire

@@ rtl/core/c2p_issue.sv @@
// ----------------------------------------------------------------------------
// c2p_issue
// Input stage: holds one item, tracks the source position, applies the
// ordered dither and issues a table write, or two table reads per cycle unless the pair buffer stalls it.
// ----------------------------------------------------------------------------
`default_nettype none

module c2p_issue (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          command_i,
  input  wire logic [15:0]                   pixel_rgb_i,
  input  wire logic                          frame_start_i,
  input  wire logic [c2p_pkg::KEY_W-1:0]     lut_address_i,
  input  wire logic [c2p_pkg::COLOR_W-1:0]   lut_color_i,
  input  wire logic                          pair_free_i,
  output c2p_pkg::c2p_wr_t                   wr_o,
  output logic      [c2p_pkg::KEY_W-1:0]     rd_even_addr_o,
  output logic      [c2p_pkg::KEY_W-1:0]     rd_odd_addr_o,
  output c2p_pkg::c2p_tag_t                  tag_o
);
  import c2p_pkg::*;

  logic               s0_valid_q;
  logic               s0_phase_q;
  logic               s0_cmd_q;
  logic [15:0]        s0_rgb_q;
  logic               s0_fs_q;
  logic [KEY_W-1:0]   s0_addr_q;
  logic [COLOR_W-1:0] s0_color_q;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  c2p_tag_t           tag_q, tag_d;

  logic [COL_W-1:0]   eff_col;
  logic [ROW_W-1:0]   eff_row;
  logic               row_end, frame_end, emit;
  logic               is_pix, pix_go, pix_done, s0_done, accept;
  logic [ROW_W+8:0]   drow_ext;
  logic [COL_W+4:0]   grp_ext;
  logic [3:0]         d_even, d_odd;

  always_comb begin
    eff_col   = s0_fs_q ? '0 : col_q;
    eff_row   = s0_fs_q ? '0 : row_q;
    row_end   = (eff_col == COL_W'(SRC_WIDTH - 1));
    frame_end = row_end && (eff_row == ROW_W'(SRC_HEIGHT - 1));
    emit      = (eff_col[2:0] == 3'd7) || row_end;
    is_pix    = s0_valid_q && !s0_cmd_q;
    // the emitting read must find the pair buffer free when it returns
    pix_go    = is_pix && (!s0_phase_q || !emit || pair_free_i);
    pix_done  = pix_go && s0_phase_q;
    s0_done   = s0_valid_q && (s0_cmd_q || pix_done);
    in_stall_o = s0_valid_q && !s0_done;
    accept    = in_valid_i && !in_stall_o;

    d_even = bayer({eff_row[0], 1'b0}, {eff_col[0], s0_phase_q});
    d_odd  = bayer({eff_row[0], 1'b1}, {eff_col[0], s0_phase_q});
    rd_even_addr_o = dither_key(s0_rgb_q, d_even);
    rd_odd_addr_o  = dither_key(s0_rgb_q, d_odd);

    wr_o.we   = s0_valid_q && s0_cmd_q;
    wr_o.addr = s0_addr_q;
    wr_o.data = s0_color_q;

    drow_ext = {8'b0, eff_row, 1'b0};
    grp_ext  = {5'b0, eff_col} >> 3;

    tag_d.valid     = pix_go;
    tag_d.phase     = s0_phase_q;
    tag_d.pos_hi    = eff_col[2:0];
    tag_d.clear     = s0_fs_q;
    tag_d.emit      = emit;
    tag_d.dest_row  = drow_ext[DROW_W-1:0];
    tag_d.grp       = grp_ext[GRP_W-1:0];
    tag_d.frame_end = frame_end;

    col_d = col_q;
    row_d = row_q;
    if (pix_done) begin
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : eff_row + ROW_W'(1);
      end else begin
        col_d = eff_col + COL_W'(1);
        row_d = eff_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s0_phase_q <= 1'b0;
      col_q      <= '0;
      row_q      <= '0;
      tag_q      <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      tag_q <= tag_d;
      if (accept) begin
        s0_valid_q <= 1'b1;
        s0_phase_q <= 1'b0;
      end else begin
        if (s0_done) begin
          s0_valid_q <= 1'b0;
        end
        if (pix_go && !s0_phase_q) begin
          s0_phase_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_cmd_q   <= command_i;
      s0_rgb_q   <= pixel_rgb_i;
      s0_fs_q    <= frame_start_i;
      s0_addr_q  <= lut_address_i;
      s0_color_q <= lut_color_i;
    end
  end

  assign tag_o = tag_q;

endmodule

`default_nettype wire

@@ rtl/core/c2p_pack.sv @@
// ----------------------------------------------------------------------------
// c2p_pack
// Merges returned palette colors into the even and odd planar words and
// hands each completed pair to the output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module c2p_pack (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire c2p_pkg::c2p_tag_t             tag_i,
  input  wire logic [c2p_pkg::COLOR_W-1:0]   color_even_i,
  input  wire logic [c2p_pkg::COLOR_W-1:0]   color_odd_i,
  input  wire logic                          lut_valid_i,
  output logic                               pair_free_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [c2p_pkg::DROW_W-1:0]    dest_row_o,
  output logic      [c2p_pkg::GRP_W-1:0]     word_group_o,
  output logic      [c2p_pkg::WORD_W-1:0]    plane_word_o,
  output logic                               last_of_pair_o,
  output logic                               last_of_frame_o
);
  import c2p_pkg::*;

  logic [WORD_W-1:0] even_q, odd_q;
  logic [WORD_W-1:0] base_even, base_odd, new_even, new_odd;
  logic [3:0]        pos;
  logic              load;

  logic [1:0]        cnt_q;
  logic [WORD_W-1:0] pb_even_q, pb_odd_q;
  logic [DROW_W-1:0] pb_row_q;
  logic [GRP_W-1:0]  pb_grp_q;
  logic              pb_fe_q;

  always_comb begin
    pos       = {tag_i.pos_hi, tag_i.phase};
    base_even = (tag_i.clear && !tag_i.phase) ? '0 : even_q;
    base_odd  = (tag_i.clear && !tag_i.phase) ? '0 : odd_q;
    new_even  = base_even | plane_mask(color_even_i, pos);
    new_odd   = base_odd  | plane_mask(color_odd_i, pos);
    load      = tag_i.valid && tag_i.phase && tag_i.emit;
    pair_free_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      even_q <= '0;
      odd_q  <= '0;
      cnt_q  <= 2'd0;
    end else begin
      if (tag_i.valid) begin
        even_q <= load ? '0 : new_even;
        odd_q  <= load ? '0 : new_odd;
      end
      if (load) begin
        cnt_q <= 2'd2;
      end else if (out_valid_o && !out_stall_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pb_even_q <= lut_valid_i ? new_even : '0;
      pb_odd_q  <= lut_valid_i ? new_odd : '0;
      pb_row_q  <= tag_i.dest_row;
      pb_grp_q  <= tag_i.grp;
      pb_fe_q   <= tag_i.frame_end;
    end
  end

  always_comb begin
    out_valid_o     = (cnt_q != 2'd0);
    last_of_pair_o  = (cnt_q == 2'd1);
    dest_row_o      = last_of_pair_o ? {pb_row_q[DROW_W-1:1], 1'b1} : pb_row_q;
    word_group_o    = pb_grp_q;
    plane_word_o    = last_of_pair_o ? pb_odd_q : pb_even_q;
    last_of_frame_o = last_of_pair_o && pb_fe_q;
  end

endmodule

`default_nettype wire

@@ rtl/core/dithered_chunky_to_planar.sv @@
// ----------------------------------------------------------------------------
// dithered_chunky_to_planar
// Chunky-to-planar converter, 4 bit planes, 2x2 pixel doubling with 4x4
// ordered dither and a 4096-entry palette table.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_stall_o  | command, pixel_rgb, frame_start,
//          |           |                        | lut_address, lut_color
//  out     | output    | out_valid_o/out_stall_i| dest_row, word_group, plane_word,
//          |           |                        | last_of_pair, last_of_frame
//  cfg     | input     | cfg_valid_i/cfg_ready_o| lut_valid (cfg_data_i)
//
// A pixel makes four palette lookups, in a first and a second phase, on the
// two read ports of the table memory. A word pair passes the table read
// register and then the output pair buffer; a pixel that completes a group
// waits while the previous pair is still held by out_stall_i.
// Reset clears position and words; the palette table is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module dithered_chunky_to_planar (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic                          cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          command_i,
  input  wire logic [15:0]                   pixel_rgb_i,
  input  wire logic                          frame_start_i,
  input  wire logic [c2p_pkg::KEY_W-1:0]     lut_address_i,
  input  wire logic [c2p_pkg::COLOR_W-1:0]   lut_color_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [c2p_pkg::DROW_W-1:0]    dest_row_o,
  output logic      [c2p_pkg::GRP_W-1:0]     word_group_o,
  output logic      [c2p_pkg::WORD_W-1:0]    plane_word_o,
  output logic                               last_of_pair_o,
  output logic                               last_of_frame_o
);
  import c2p_pkg::*;

  logic               lut_valid_q;
  c2p_wr_t            wr;
  c2p_tag_t           tag;
  logic [KEY_W-1:0]   rd_even_addr, rd_odd_addr;
  logic [COLOR_W-1:0] color_even, color_odd;
  logic               pair_free;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lut_valid_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      lut_valid_q <= cfg_data_i;
    end
  end

  c2p_issue u_issue (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .pixel_rgb_i    (pixel_rgb_i),
    .frame_start_i  (frame_start_i),
    .lut_address_i  (lut_address_i),
    .lut_color_i    (lut_color_i),
    .pair_free_i    (pair_free),
    .wr_o           (wr),
    .rd_even_addr_o (rd_even_addr),
    .rd_odd_addr_o  (rd_odd_addr),
    .tag_o          (tag)
  );

  c2p_lut_ram u_lut_ram (
    .clk_i       (clk_i),
    .wr_i        (wr),
    .rd_addr_a_i (rd_even_addr),
    .rd_addr_b_i (rd_odd_addr),
    .rd_data_a_o (color_even),
    .rd_data_b_o (color_odd)
  );

  c2p_pack u_pack (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tag_i           (tag),
    .color_even_i    (color_even),
    .color_odd_i     (color_odd),
    .lut_valid_i     (lut_valid_q),
    .pair_free_o     (pair_free),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .dest_row_o      (dest_row_o),
    .word_group_o    (word_group_o),
    .plane_word_o    (plane_word_o),
    .last_of_pair_o  (last_of_pair_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule

`default_nettype wire

@@ bench/dithered_chunky_to_planar_test.sv @@
// ----------------------------------------------------------------------------
// dithered_chunky_to_planar_test
// Self-checking bench for the dithered chunky-to-planar converter. A queue of
// pixels and palette writes feeds a clocked driver. Each accepted item runs
// through a local model of the dither, palette lookup and plane packing, and
// the monitor checks every planar word against the oldest predicted word.
// Phases: directed corners, then random traffic with sender gaps, receiver
// stalls and a long receiver hold-off.
// ----------------------------------------------------------------------------
module dithered_chunky_to_planar_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COLS = c2p_pkg::SRC_WIDTH;
  localparam int unsigned ROWS = c2p_pkg::SRC_HEIGHT;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_ITEMS  = 440;

  // 4x4 ordered dither, nibble (y*4 + x)
  localparam logic [63:0] BAYER_NIBBLES = 64'h5D7F_91B3_6E4C_A280;

  typedef enum logic {
    CMD_PIXEL     = 1'b0,
    CMD_LUT_WRITE = 1'b1
  } c2p_cmd_e;

  typedef struct {
    c2p_cmd_e                       cmd;
    logic [15:0]                    rgb;
    logic                           frame_start;
    logic [c2p_pkg::KEY_W-1:0]      addr;
    logic [c2p_pkg::COLOR_W-1:0]    color;
  } c2p_item_t;

  typedef struct packed {
    logic [c2p_pkg::DROW_W-1:0] dest_row;
    logic [c2p_pkg::GRP_W-1:0]  word_group;
    logic [c2p_pkg::WORD_W-1:0] planes;
    logic                       pair_last;
    logic                       frame_last;
  } planar_word_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic                            cfg_data_i = 1'b0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  logic                            command_i = 1'b0;
  logic [15:0]                     pixel_rgb_i = '0;
  logic                            frame_start_i = 1'b0;
  logic [c2p_pkg::KEY_W-1:0]       lut_address_i = '0;
  logic [c2p_pkg::COLOR_W-1:0]     lut_color_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [c2p_pkg::DROW_W-1:0]      dest_row_o;
  logic [c2p_pkg::GRP_W-1:0]       word_group_o;
  logic [c2p_pkg::WORD_W-1:0]      plane_word_o;
  logic                            last_of_pair_o;
  logic                            last_of_frame_o;

  dithered_chunky_to_planar uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // stimulus side
  c2p_item_t    items_to_send [$];
  c2p_item_t    item_on_port;
  int           items_queued = 0;
  int           items_accepted = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_requests = 0;
  int           holds_served = 0;
  int           hold_left = 0;
  int           gen_col = 0;
  int           gen_row = 0;
  bit           lut_loaded [4096];

  // prediction side
  planar_word_t                 words_due [$];
  logic                         lut_on = 1'b0;
  logic [c2p_pkg::COLOR_W-1:0]  palette [4096];
  int                           pos_col = 0;
  int                           pos_row = 0;
  logic [c2p_pkg::WORD_W-1:0]   even_acc = '0;
  logic [c2p_pkg::WORD_W-1:0]   odd_acc = '0;
  int                           mismatches = 0;

  function automatic logic [3:0] dither_chan(input logic [3:0] c, input logic [3:0] d);
    int v;
    v = int'(c) + int'(d[3:2]) - 2;
    if (v < 0) return 4'd0;
    if (v > 15) return 4'd15;
    return v[3:0];
  endfunction

  function automatic logic [c2p_pkg::KEY_W-1:0] dither_key_at(input logic [15:0] rgb,
                                                              input int dx, input int dy);
    logic [3:0] d;
    d = BAYER_NIBBLES[(4 * (dy % 4) + dx % 4) * 4 +: 4];
    return {dither_chan(rgb[15:12], d), dither_chan(rgb[11:8], d), dither_chan(rgb[3:0], d)};
  endfunction

  function automatic logic [c2p_pkg::WORD_W-1:0] plane_bits(
      input logic [c2p_pkg::COLOR_W-1:0] color, input int dx);
    logic [c2p_pkg::WORD_W-1:0] m;
    int p;
    m = '0;
    for (p = 0; p < 4; p++) begin
      m[p * 16 + 15 - dx % 16] = color[p];
    end
    return m;
  endfunction

  function automatic string word_text(input planar_word_t w);
    return $sformatf("row %0d group %0d word %016h pair %b frame %b",
                     w.dest_row, w.word_group, w.planes, w.pair_last, w.frame_last);
  endfunction

  task automatic convert_item(input c2p_item_t it);
    int dx;
    int dy;
    int ox;
    logic row_end;
    logic frame_end;
    planar_word_t w;
    if (it.cmd == CMD_LUT_WRITE) begin
      palette[it.addr] = it.color;
      return;
    end
    if (it.frame_start) begin
      pos_col = 0;
      pos_row = 0;
      even_acc = '0;
      odd_acc = '0;
    end
    dy = 2 * pos_row;
    for (ox = 0; ox < 2; ox++) begin
      dx = 2 * pos_col + ox;
      even_acc |= plane_bits(palette[dither_key_at(it.rgb, dx, dy)], dx);
      odd_acc |= plane_bits(palette[dither_key_at(it.rgb, dx, dy + 1)], dx);
    end
    row_end = (pos_col + 1 >= int'(COLS));
    frame_end = row_end && (pos_row + 1 >= int'(ROWS));
    if (pos_col % 8 == 7 || row_end) begin
      w.dest_row = dy[7:0];
      w.word_group = 5'(pos_col / 8);
      w.planes = lut_on ? even_acc : '0;
      w.pair_last = 1'b0;
      w.frame_last = 1'b0;
      words_due.push_back(w);
      w.dest_row = 8'(dy + 1);
      w.planes = lut_on ? odd_acc : '0;
      w.pair_last = 1'b1;
      w.frame_last = frame_end;
      words_due.push_back(w);
      even_acc = '0;
      odd_acc = '0;
      if (row_end) begin
        pos_col = 0;
        pos_row = frame_end ? 0 : pos_row + 1;
      end else begin
        pos_col++;
      end
    end else begin
      pos_col++;
    end
  endtask

  task automatic send(input c2p_item_t it);
    items_to_send.push_back(it);
    items_queued++;
  endtask

  task automatic queue_lut_write(input logic [11:0] addr, input logic [3:0] color,
                                 input logic fs);
    c2p_item_t it;
    it.cmd = CMD_LUT_WRITE;
    it.rgb = 16'($urandom);
    it.frame_start = fs;
    it.addr = addr;
    it.color = color;
    lut_loaded[addr] = 1'b1;
    send(it);
  endtask

  // loads any palette entry this pixel will look up before the pixel itself
  task automatic queue_pixel(input logic [15:0] rgb, input logic fs);
    c2p_item_t it;
    int ox;
    int oy;
    logic [11:0] key;
    if (fs) begin
      gen_col = 0;
      gen_row = 0;
    end
    for (oy = 0; oy < 2; oy++) begin
      for (ox = 0; ox < 2; ox++) begin
        key = dither_key_at(rgb, 2 * gen_col + ox, 2 * gen_row + oy);
        if (!lut_loaded[key]) begin
          queue_lut_write(key, 4'($urandom_range(15)), 1'($urandom_range(1)));
        end
      end
    end
    it.cmd = CMD_PIXEL;
    it.rgb = rgb;
    it.frame_start = fs;
    it.addr = 12'($urandom);
    it.color = 4'($urandom);
    send(it);
    gen_col++;
    if (gen_col == int'(COLS)) begin
      gen_col = 0;
      gen_row = (gen_row + 1 == int'(ROWS)) ? 0 : gen_row + 1;
    end
  endtask

  // queues about n items, palette fills included
  task automatic queue_random(input int n);
    int r;
    int stop;
    stop = items_queued + n;
    while (items_queued < stop) begin
      r = $urandom_range(99);
      if (r < 8) begin
        queue_lut_write(12'($urandom), 4'($urandom), 1'($urandom));
      end else if (r < 55) begin
        // coarse channel values keep the set of palette keys small
        queue_pixel(16'($urandom) & 16'hCCFC, r >= 53);
      end else begin
        queue_pixel(16'($urandom), r >= 97);
      end
    end
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct);
    send_idle_pct <= send_pct;
    recv_stall_pct <= stall_pct;
  endtask

  task automatic write_lut_valid(input logic v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    lut_on = v;
  endtask

  task automatic drain_block();
    int waited;
    waited = 0;
    do @(posedge clk_i); while (items_accepted != items_queued);
    while (words_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_word();
    planar_word_t got;
    planar_word_t want;
    got.dest_row = dest_row_o;
    got.word_group = word_group_o;
    got.planes = plane_word_o;
    got.pair_last = last_of_pair_o;
    got.frame_last = last_of_frame_o;
    if (words_due.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("unexpected item: %s", word_text(got));
    end else begin
      want = words_due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("mismatch: expected %s, got %s", word_text(want), word_text(got));
        end
      end
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        convert_item(item_on_port);
        items_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item_on_port = items_to_send.pop_front();
          in_valid_i <= 1'b1;
          command_i <= item_on_port.cmd;
          pixel_rgb_i <= item_on_port.rgb;
          frame_start_i <= item_on_port.frame_start;
          lut_address_i <= item_on_port.addr;
          lut_color_i <= item_on_port.color;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      hold_left <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_word();
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    int failures;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    set_idling(0, 0);
    write_lut_valid(1'b1);
    queue_lut_write(12'h000, 4'hF, 1'b0);
    queue_lut_write(12'hFFF, 4'h0, 1'b0);
    queue_lut_write(12'hA5A, 4'h5, 1'b1);
    queue_pixel(16'h0000, 1'b1);
    queue_pixel(16'hFFFF, 1'b0);
    queue_pixel(16'h00F0, 1'b0);
    queue_pixel(16'hFF0F, 1'b0);
    queue_pixel(16'h1111, 1'b0);
    queue_pixel(16'hEEEE, 1'b0);
    queue_pixel(16'h8421, 1'b0);
    queue_pixel(16'h7F3C, 1'b0);
    queue_pixel(16'h0F0F, 1'b0);
    queue_pixel(16'hF0F0, 1'b0);
    queue_pixel(16'h2222, 1'b0);
    queue_lut_write(12'h123, 4'hA, 1'b1);
    queue_pixel(16'h5A5A, 1'b1);
    repeat (7) queue_pixel(16'($urandom), 1'b0);
    drain_block();

    set_idling(62, 0);
    write_lut_valid(1'b0);
    queue_random(RANDOM_ITEMS);
    drain_block();

    set_idling(0, 62);
    write_lut_valid(1'b1);
    hold_requests <= hold_requests + 1;
    queue_random(RANDOM_ITEMS);
    drain_block();

    set_idling(38, 38);
    queue_random(RANDOM_ITEMS);
    drain_block();

    failures = mismatches + words_due.size() + (items_queued - items_accepted);
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2400000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
